### rtl/rrc_pkg.sv
package rrc_pkg;

   localparam int FRACTION_BITS_DEFAULT = 22;

   localparam int CRYSTAL_W  = 26;
   localparam int PPM_W      = 11;
   localparam int FACTOR_W   = 20;
   localparam int PRODUCT_W  = CRYSTAL_W + FACTOR_W;
   localparam int XTAL_W     = 27;
   localparam int RECIP_W    = 32;
   localparam int RATE_W     = 32;
   localparam int RATIO_W    = 28;
   localparam int EFF_W      = 29;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 26;

   localparam logic [RATE_W-1:0]     RATE_MIN      = 32'd225000;
   localparam logic [RATE_W-1:0]     RATE_MAX      = 32'd3200000;
   localparam logic [FACTOR_W-1:0]   PPM_SCALE     = 20'd1000000;
   localparam logic [CRYSTAL_W-1:0]  CRYSTAL_RESET = 26'd28800000;
   localparam logic [PPM_W-1:0]      PPM_RESET     = 11'd0;
   localparam logic [RATE_W-1:0]     RATIO_MASK    = 32'h0FFF_FFFC;
   // floor(2^51 / 1e6): reciprocal of the ppm scale for the top product bits
   localparam logic [RECIP_W-1:0]    XTAL_RECIP    = 32'd2251799813;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CRYSTAL = 2'd0,
      CSR_PPM     = 2'd1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_ZERO  = 2'd2
   } status_type;

endpackage

### rtl/rrc_divider.sv
// Restoring divider, one quotient bit per register stage.
module rrc_divider #(
   parameter int NUM_W  = 46,
   parameter int DEN_W  = 20,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_dividend,
   input  logic [DEN_W-1:0]  in_divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quotient,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  dvd_ff  [NUM_W];
   logic [DEN_W-1:0]  dsr_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   logic              cur_vld  [NUM_W];
   logic [DEN_W-1:0]  cur_rem  [NUM_W];
   logic [NUM_W-1:0]  cur_dvd  [NUM_W];
   logic [DEN_W-1:0]  cur_dsr  [NUM_W];
   logic [NUM_W-1:0]  cur_quo  [NUM_W];
   logic [SIDE_W-1:0] cur_side [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic             fits;
      logic [DEN_W:0]   diff;

      if (i == 0) begin : g_first
         assign cur_vld[i]  = in_valid;
         assign cur_rem[i]  = '0;
         assign cur_dvd[i]  = in_dividend;
         assign cur_dsr[i]  = in_divisor;
         assign cur_quo[i]  = '0;
         assign cur_side[i] = in_side;
      end else begin : g_next
         assign cur_vld[i]  = vld_ff[i-1];
         assign cur_rem[i]  = rem_ff[i-1];
         assign cur_dvd[i]  = dvd_ff[i-1];
         assign cur_dsr[i]  = dsr_ff[i-1];
         assign cur_quo[i]  = quo_ff[i-1];
         assign cur_side[i] = side_ff[i-1];
      end

      assign trial = {cur_rem[i], cur_dvd[i][NUM_W-1-i]};
      assign fits  = trial >= {1'b0, cur_dsr[i]};
      assign diff  = trial - {1'b0, cur_dsr[i]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= cur_vld[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            dvd_ff[i]  <= cur_dvd[i];
            dsr_ff[i]  <= cur_dsr[i];
            quo_ff[i]  <= {cur_quo[i][NUM_W-2:0], fits};
            side_ff[i] <= cur_side[i];
         end
      end
   end

   assign out_valid    = vld_ff[NUM_W-1];
   assign out_quotient = quo_ff[NUM_W-1];
   assign out_side     = side_ff[NUM_W-1];

endmodule

### rtl/resampler_ratio_calc_top.sv
// Channel  | Handshake             | Payload
// request  | req_valid / req_stall | req_requested_rate
// response | rsp_valid / rsp_stall | rsp_status, rsp_ratio_word, rsp_achieved_rate
// config   | csr_write_enable      | csr_index, csr_write_data
//
// One transaction enters per cycle unless a valid response is stalled. The stages are:
// a multiply stage, three stages that divide the product by 1e6 (reciprocal
// estimate, back-multiply, one-step fixup), two bit-per-stage dividers (ratio,
// achieved rate) of 27 + FRACTION_BITS stages each, and the output register.
// Reset is synchronous and clears only valid bits and the two configuration
// registers. A stall on a valid response freezes the whole pipeline; the request side
// stalls only then.
module resampler_ratio_calc_top #(
   parameter int FRACTION_BITS = rrc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rrc_pkg::RATE_W-1:0]      req_requested_rate,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rrc_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rrc_pkg::RATIO_W-1:0]     rsp_ratio_word,
   output logic [rrc_pkg::RATE_W-1:0]      rsp_achieved_rate,
   input  logic                            csr_write_enable,
   input  logic [rrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int SCALED_W = rrc_pkg::XTAL_W + FRACTION_BITS;
   localparam int SIDE1_W  = 1 + rrc_pkg::RATE_W;
   localparam int SIDE2_W  = 1 + SCALED_W;
   localparam int SIDE3_W  = rrc_pkg::STATUS_W + rrc_pkg::RATIO_W;
   localparam int EST_W    = rrc_pkg::XTAL_W + rrc_pkg::RECIP_W;

   // Configuration registers.
   logic [rrc_pkg::CRYSTAL_W-1:0] crystal_ff;
   logic [rrc_pkg::PPM_W-1:0]     ppm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crystal_ff <= rrc_pkg::CRYSTAL_RESET;
         ppm_ff     <= rrc_pkg::PPM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rrc_pkg::CSR_CRYSTAL: crystal_ff <= csr_write_data[rrc_pkg::CRYSTAL_W-1:0];
            rrc_pkg::CSR_PPM:     ppm_ff     <= csr_write_data[rrc_pkg::PPM_W-1:0];
            default: ;  // drop writes to unknown registers
         endcase
      end
   end

   // Whole pipeline moves together; hold everything while the result waits.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Stage 0: range check and crystal * (1e6 + ppm).
   logic [rrc_pkg::FACTOR_W-1:0]  factor;
   logic                          range_err;
   logic                          s0_valid_ff;
   logic [rrc_pkg::PRODUCT_W-1:0] s0_prod_ff;
   logic [rrc_pkg::RATE_W-1:0]    s0_rate_ff;
   logic                          s0_err_ff;

   // Modulo 2^20 sum; the result is always positive and below 2^20.
   assign factor = rrc_pkg::PPM_SCALE
                 + {{(rrc_pkg::FACTOR_W-rrc_pkg::PPM_W){ppm_ff[rrc_pkg::PPM_W-1]}}, ppm_ff};
   assign range_err = (req_requested_rate < rrc_pkg::RATE_MIN)
                   || (req_requested_rate > rrc_pkg::RATE_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_prod_ff <= rrc_pkg::PRODUCT_W'(crystal_ff) * rrc_pkg::PRODUCT_W'(factor);
         s0_rate_ff <= req_requested_rate;
         s0_err_ff  <= range_err;
      end
   end

   // Corrected crystal = product / 1e6. Multiply the top 27 product bits by the
   // reciprocal; the estimate is the quotient or one below it. Multiply back,
   // and bump the estimate when the remainder still holds another 1e6.
   logic [rrc_pkg::XTAL_W-1:0]    prod_hi;
   logic [EST_W-1:0]              est_prod;
   logic [rrc_pkg::PRODUCT_W-1:0] rem;
   logic                          bump;
   logic                          c1_valid_ff;
   logic [rrc_pkg::XTAL_W-1:0]    c1_est_ff;
   logic [rrc_pkg::PRODUCT_W-1:0] c1_prod_ff;
   logic [SIDE1_W-1:0]            c1_side_ff;
   logic                          c2_valid_ff;
   logic [rrc_pkg::XTAL_W-1:0]    c2_est_ff;
   logic [rrc_pkg::PRODUCT_W-1:0] c2_prod_ff;
   logic [rrc_pkg::PRODUCT_W-1:0] c2_back_ff;
   logic [SIDE1_W-1:0]            c2_side_ff;
   logic                          c3_valid_ff;
   logic [rrc_pkg::XTAL_W-1:0]    c3_xtal_ff;
   logic [SIDE1_W-1:0]            c3_side_ff;

   assign prod_hi  = s0_prod_ff[rrc_pkg::PRODUCT_W-1 -: rrc_pkg::XTAL_W];
   assign est_prod = EST_W'(prod_hi) * EST_W'(rrc_pkg::XTAL_RECIP);
   assign rem      = c2_prod_ff - c2_back_ff;
   assign bump     = rem >= rrc_pkg::PRODUCT_W'(rrc_pkg::PPM_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
      end else if (advance) begin
         c1_valid_ff <= s0_valid_ff;
         c2_valid_ff <= c1_valid_ff;
         c3_valid_ff <= c2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_est_ff  <= est_prod[EST_W-1 -: rrc_pkg::XTAL_W];
         c1_prod_ff <= s0_prod_ff;
         c1_side_ff <= {s0_err_ff, s0_rate_ff};
         c2_est_ff  <= c1_est_ff;
         c2_prod_ff <= c1_prod_ff;
         c2_back_ff <= rrc_pkg::PRODUCT_W'(c1_est_ff)
                     * rrc_pkg::PRODUCT_W'(rrc_pkg::PPM_SCALE);
         c2_side_ff <= c1_side_ff;
         c3_xtal_ff <= c2_est_ff + rrc_pkg::XTAL_W'(bump);
         c3_side_ff <= c2_side_ff;
      end
   end

   // Divider 2: ratio = (xtal << FRACTION_BITS) / rate.
   logic [SCALED_W-1:0] scaled;
   logic                d2_valid;
   logic [SCALED_W-1:0] d2_quo;
   logic [SIDE2_W-1:0]  d2_side;

   assign scaled = {c3_xtal_ff, {FRACTION_BITS{1'b0}}};

   rrc_divider #(
      .NUM_W  (SCALED_W),
      .DEN_W  (rrc_pkg::RATE_W),
      .SIDE_W (SIDE2_W)
   ) u_div_ratio (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (c3_valid_ff),
      .in_dividend  (scaled),
      .in_divisor   (c3_side_ff[rrc_pkg::RATE_W-1:0]),
      .in_side      ({c3_side_ff[SIDE1_W-1], scaled}),
      .out_valid    (d2_valid),
      .out_quotient (d2_quo),
      .out_side     (d2_side)
   );

   // Mask the ratio, classify, and build the effective divisor.
   logic [rrc_pkg::RATE_W-1:0]  ratio_full;
   logic [rrc_pkg::RATIO_W-1:0] ratio;
   logic [rrc_pkg::EFF_W-1:0]   eff;
   rrc_pkg::status_type         status2;

   assign ratio_full = d2_quo[rrc_pkg::RATE_W-1:0] & rrc_pkg::RATIO_MASK;
   assign ratio      = ratio_full[rrc_pkg::RATIO_W-1:0];
   assign eff        = {ratio[rrc_pkg::RATIO_W-1], ratio};

   always_comb begin
      if (d2_side[SIDE2_W-1]) begin
         status2 = rrc_pkg::STATUS_RANGE;
      end else if (ratio == '0) begin
         status2 = rrc_pkg::STATUS_ZERO;
      end else begin
         status2 = rrc_pkg::STATUS_OK;
      end
   end

   // Divider 3: achieved = scaled / effective ratio.
   logic                d3_valid;
   logic [SCALED_W-1:0] d3_quo;
   logic [SIDE3_W-1:0]  d3_side;

   rrc_divider #(
      .NUM_W  (SCALED_W),
      .DEN_W  (rrc_pkg::EFF_W),
      .SIDE_W (SIDE3_W)
   ) u_div_achieved (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (d2_valid),
      .in_dividend  (d2_side[SCALED_W-1:0]),
      .in_divisor   (eff),
      .in_side      ({status2, ratio}),
      .out_valid    (d3_valid),
      .out_quotient (d3_quo),
      .out_side     (d3_side)
   );

   // Output register: zero the payload on any error status.
   logic [rrc_pkg::STATUS_W-1:0] status_in;
   logic                         ok3;
   logic [rrc_pkg::STATUS_W-1:0] status_ff;
   logic [rrc_pkg::RATIO_W-1:0]  ratio_ff;
   logic [rrc_pkg::RATE_W-1:0]   achieved_ff;

   assign status_in = d3_side[SIDE3_W-1 -: rrc_pkg::STATUS_W];
   assign ok3       = status_in == rrc_pkg::STATUS_OK;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff   <= status_in;
         ratio_ff    <= ok3 ? d3_side[rrc_pkg::RATIO_W-1:0] : '0;
         achieved_ff <= ok3 ? d3_quo[rrc_pkg::RATE_W-1:0] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_ratio_word    = ratio_ff;
   assign rsp_achieved_rate = achieved_ff;

`ifndef NO_ASSERTIONS
   a_err_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rrc_pkg::STATUS_OK)
      |-> (rsp_ratio_word == '0) && (rsp_achieved_rate == '0))
      else $error("error transaction carries nonzero payload");

   a_ok_ratio_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rrc_pkg::STATUS_OK)
      |-> (rsp_ratio_word != '0) && (rsp_ratio_word[1:0] == 2'b00))
      else $error("ok transaction with malformed ratio");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_ratio_word) && $stable(rsp_achieved_rate))
      else $error("stalled response changed");
`endif

endmodule
